// ===== sv/asbm_pkg.sv =====
// Shared constants, register codes and pipeline control type of the bitap matcher.
package asbm_pkg;

  // Fixed field widths
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 6;
  localparam int ERR_W         = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int PATTERN_BYTES = 32;
  localparam int PATTERN_BITS  = PATTERN_BYTES * CHAR_W;

  // Parameter defaults
  localparam int PATTERN_MAX_DEF      = 32;
  localparam int MAX_ERRORS_BOUND_DEF = 7;
  localparam int POSITION_BITS_DEF    = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ERRORS       = 3'd5;

  // Control that travels with each byte along the chain
  typedef struct packed {
    logic valid;
    logic first;
    logic hit;
  } ctl_t;

endpackage

// ===== sv/asbm_front.sv =====
// Front stage: builds the pattern position set for each text byte.
module asbm_front #(
  parameter int PATTERN_MAX = asbm_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [asbm_pkg::CHAR_W-1:0]      text_char,
  input  logic                             first_of_string,
  input  logic [asbm_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [asbm_pkg::LEN_W-1:0]       pattern_length,
  output logic [PATTERN_MAX-1:0]           s_out,
  output asbm_pkg::ctl_t                   ctl_out
);
  import asbm_pkg::*;

  logic [PATTERN_MAX-1:0] s_next;
  logic                   char_live;

  // A zero byte matches nothing
  assign char_live = (text_char != '0);

  // Compare the byte against every pattern position in use
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i < PATTERN_BYTES) begin : g_real
      assign s_next[i] = char_live
                         && ((LEN_W+1)'(i) < {1'b0, pattern_length})
                         && (pattern[i*CHAR_W +: CHAR_W] == text_char);
    end else begin : g_blank
      assign s_next[i] = 1'b0;
    end
  end

  // Advance the stage on every enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= in_valid;
      ctl_out.first <= first_of_string;
      ctl_out.hit   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      s_out <= s_next;
    end
  end

endmodule

// ===== sv/asbm_cell.sv =====
// One error row of the bitap recurrence, as a stage of the systolic chain.
module asbm_cell #(
  parameter int PATTERN_MAX = asbm_pkg::PATTERN_MAX_DEF,
  parameter int K_W         = 3,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [K_W-1:0]         k_sel,
  input  logic [PATTERN_MAX-1:0] last_mask,
  input  logic [PATTERN_MAX-1:0] s_in,
  input  asbm_pkg::ctl_t         ctl_in,
  input  logic [PATTERN_MAX-1:0] prev_old,
  input  logic [PATTERN_MAX-1:0] prev_new,
  output logic [PATTERN_MAX-1:0] s_out,
  output asbm_pkg::ctl_t         ctl_out,
  output logic [PATTERN_MAX-1:0] old_out,
  output logic [PATTERN_MAX-1:0] row
);
  import asbm_pkg::*;

  logic [PATTERN_MAX-1:0] reload;
  logic [PATTERN_MAX-1:0] old_eff;
  logic [PATTERN_MAX-1:0] base;
  logic [PATTERN_MAX-1:0] row_next;
  logic                   hit_next;

  // Reload value: the low IDX bits set
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_reload
    assign reload[i] = (i < IDX);
  end

  // Restart the row at the first byte of a string
  assign old_eff = ctl_in.first ? reload : row;
  assign base    = {old_eff[PATTERN_MAX-2:0], 1'b1} & s_in;

  if (IDX == 0) begin : g_exact
    assign row_next = base;
  end else begin : g_approx
    logic [PATTERN_MAX-1:0] prev_or;
    assign prev_or  = prev_old | prev_new;
    assign row_next = base | {prev_or[PATTERN_MAX-2:0], 1'b1} | prev_old;
  end

  // Pick up the match bit when this row is the selected error limit
  assign hit_next = (k_sel == K_W'(IDX)) ? |(row_next & last_mask) : ctl_in.hit;

  // Hold the row as state and hand the byte on to the next row
  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= reload;
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
      if (ctl_in.valid) begin
        row           <= row_next;
        ctl_out.first <= ctl_in.first;
        ctl_out.hit   <= hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl_in.valid) begin
      s_out   <= s_in;
      old_out <= old_eff;
    end
  end

endmodule

// ===== sv/asbm_tail.sv =====
// Tail stage: first-match flag, sticky found flag and saturating byte position.
module asbm_tail #(
  parameter int POSITION_BITS = asbm_pkg::POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  asbm_pkg::ctl_t           ctl_in,
  output logic                     out_valid,
  output logic                     match_here,
  output logic                     found_so_far,
  output logic [POSITION_BITS-1:0] char_position
);
  import asbm_pkg::*;

  logic                     found;
  logic                     found_eff;
  logic [POSITION_BITS-1:0] count;
  logic [POSITION_BITS-1:0] pos_eff;
  logic [POSITION_BITS-1:0] count_next;

  // Restart flag and position at the first byte of a string
  assign found_eff  = ctl_in.first ? 1'b0 : found;
  assign pos_eff    = ctl_in.first ? '0 : count;
  assign count_next = (pos_eff == '1) ? pos_eff : pos_eff + 1'b1;

  // Advance string state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_in.valid;
      if (ctl_in.valid) begin
        found <= found_eff | ctl_in.hit;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl_in.valid) begin
      match_here    <= ctl_in.hit & ~found_eff;
      found_so_far  <= found_eff | ctl_in.hit;
      char_position <= pos_eff;
    end
  end

endmodule

// ===== sv/approx_substring_bitap_matcher.sv =====
// Pipeline: front stage, one cell per error row, then the tail result register.
// Throughput: one text byte per cycle unless stalled; each cell is a pipeline stage.
// The whole chain advances together whenever the result register is empty or taken.
// Reset clears the pipeline, loads row d with its low d bits set, zeroes position
// and found flag, and sets pattern length to 1, error limit to 0, pattern bytes to 0.
module approx_substring_bitap_matcher #(
  parameter int PATTERN_MAX      = asbm_pkg::PATTERN_MAX_DEF,
  parameter int MAX_ERRORS_BOUND = asbm_pkg::MAX_ERRORS_BOUND_DEF,
  parameter int POSITION_BITS    = asbm_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [asbm_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [asbm_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [asbm_pkg::CHAR_W-1:0]       text_char,
  input  logic                              first_of_string,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              match_here,
  output logic                              found_so_far,
  output logic [POSITION_BITS-1:0]          char_position
);
  import asbm_pkg::*;

  localparam int ROWS = MAX_ERRORS_BOUND + 1;
  localparam int K_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int M_W  = LEN_W + 1;

  logic [PATTERN_BITS-1:0] pattern;
  logic [LEN_W-1:0]        pattern_length;
  logic [ERR_W-1:0]        max_errors;

  logic                    en;
  logic [M_W-1:0]          m_eff;
  logic [K_W-1:0]          k_sel;
  logic [PATTERN_MAX-1:0]  last_mask;

  logic [PATTERN_MAX-1:0]  s_pipe   [ROWS+1];
  logic [PATTERN_MAX-1:0]  old_pipe [ROWS+1];
  logic [PATTERN_MAX-1:0]  row_pipe [ROWS+1];
  ctl_t                    ctl_pipe [ROWS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= LEN_W'(1);
      max_errors     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PATTERN_LOW:      pattern[0*CFG_DATA_W +: CFG_DATA_W] <= wr_data;
        REG_PATTERN_MID_LOW:  pattern[1*CFG_DATA_W +: CFG_DATA_W] <= wr_data;
        REG_PATTERN_MID_HIGH: pattern[2*CFG_DATA_W +: CFG_DATA_W] <= wr_data;
        REG_PATTERN_HIGH:     pattern[3*CFG_DATA_W +: CFG_DATA_W] <= wr_data;
        REG_PATTERN_LENGTH:   pattern_length <= wr_data[LEN_W-1:0];
        REG_MAX_ERRORS:       max_errors     <= wr_data[ERR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length and error limit to what the chain holds
  assign m_eff = ({1'b0, pattern_length} > M_W'(PATTERN_MAX)) ? M_W'(PATTERN_MAX)
                                                               : {1'b0, pattern_length};
  assign k_sel = (32'(max_errors) > MAX_ERRORS_BOUND) ? K_W'(MAX_ERRORS_BOUND)
                                                      : K_W'(max_errors);

  // Mark the bit of the last pattern position
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_mask
    assign last_mask[i] = (m_eff != '0) && (m_eff == M_W'(i + 1));
  end

  // Stall the whole chain while a result waits
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  asbm_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (in_valid),
    .text_char       (text_char),
    .first_of_string (first_of_string),
    .pattern         (pattern),
    .pattern_length  (pattern_length),
    .s_out           (s_pipe[0]),
    .ctl_out         (ctl_pipe[0])
  );

  // Row zero has no lower neighbor
  assign old_pipe[0] = '0;
  assign row_pipe[0] = '0;

  for (genvar d = 0; d < ROWS; d++) begin : g_cell
    asbm_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .K_W         (K_W),
      .IDX         (d)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .k_sel     (k_sel),
      .last_mask (last_mask),
      .s_in      (s_pipe[d]),
      .ctl_in    (ctl_pipe[d]),
      .prev_old  (old_pipe[d]),
      .prev_new  (row_pipe[d]),
      .s_out     (s_pipe[d+1]),
      .ctl_out   (ctl_pipe[d+1]),
      .old_out   (old_pipe[d+1]),
      .row       (row_pipe[d+1])
    );
  end

  asbm_tail #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tail (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .ctl_in        (ctl_pipe[ROWS]),
    .out_valid     (out_valid),
    .match_here    (match_here),
    .found_so_far  (found_so_far),
    .char_position (char_position)
  );

endmodule
